### rtl/core/sparse_multitau_correlator_defines.svh
// Assertion shorthands used by the bound checker smtc_checker.
`ifndef SPARSE_MULTITAU_CORRELATOR_DEFINES_SVH
`define SPARSE_MULTITAU_CORRELATOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define SMTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define SMTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/smtc_pkg.sv
package smtc_pkg;

    typedef struct packed {
        logic [19:0] pixel_id;
        logic [11:0] event_frame;
        logic [15:0] event_value;
        logic        last_event;
    } smtc_in_t;

    typedef struct packed {
        logic [19:0] out_pixel;
        logic [5:0]  delay_index;
        logic [11:0] delay_frames;
        logic [47:0] g2_mean;
        logic [31:0] past_mean;
        logic [31:0] future_mean;
        logic        last_result;
    } smtc_out_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAYS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 2'd2;

    localparam logic [12:0] FRAME_LIMIT = 13'd4096;

endpackage

### rtl/core/sparse_multitau_correlator.sv
// Loads one pixel's events (one transfer per cycle, s_ready high while loading) into a
// frame/value event memory with two registered read ports and one write port. The
// transfer flagged last_event starts the multi-tau pass: a schedule count pass over
// the delays and levels, then per delay a schedule step, a rebin of the stored events
// on level change, a correlation pass (each event read, then partner probes, with a
// multiply-accumulate per matching pair; the probe pointer only rewinds when the target
// frame drops, so ordered input stays linear in the event count), the shared restoring
// divider for the three means, and the hand-off of the result to the output register.
// Results leave in schedule order with last_result on the final delay; the next pixel's
// events are taken while that final result still waits on m_ready. Configuration is
// written through the cfg port, which is always ready; the user must write it only
// while the block is idle, since the block itself does not enforce this.
module sparse_multitau_correlator #(
    parameter int MAX_EVENTS = 4096,
    parameter int MAX_DELAYS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  smtc_pkg::smtc_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output smtc_pkg::smtc_out_t                   m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [smtc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [smtc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import smtc_pkg::*;

    localparam int AW        = $clog2(MAX_EVENTS);
    localparam int CW        = $clog2(MAX_EVENTS + 1);
    localparam int NDW       = $clog2(MAX_DELAYS + 1);
    localparam int DIV_STEPS = 64;
    localparam int DCW       = $clog2(DIV_STEPS);
    localparam int SHW       = 16 + FRAC_BITS;

    typedef enum logic [3:0] {
        S_LOAD, S_COUNT, S_NEXT, S_REB_RD, S_REB_PROC, S_REB_FLUSH, S_CORR_INIT,
        S_CORR_RD, S_CORR_GET, S_SRCH_RD, S_SRCH_CHK, S_MAC, S_DIV, S_EMIT
    } state_t;

    typedef enum logic [1:0] {DS_PROD, DS_PAST, DS_FUT} div_sel_t;

    // event memory
    logic [11:0] frame_mem [MAX_EVENTS];
    logic [31:0] value_mem [MAX_EVENTS];
    logic [11:0] rd_frame_a_reg, rd_frame_b_reg;
    logic [31:0] rd_value_a_reg, rd_value_b_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [11:0]   mem_wframe;
    logic [31:0]   mem_wvalue;
    logic [AW-1:0] rd_addr_a, rd_addr_b;

    state_t       state_reg;
    logic [12:0]  frame_count_reg;
    logic [5:0]   delays_reg;
    logic [3:0]   max_level_reg;
    logic [CW-1:0] event_total_reg;
    logic [19:0]  pixel_reg;
    logic [12:0]  bf_reg;
    logic [3:0]   level_reg;

    logic [4:0]     sw_lvl_reg;
    logic [6:0]     sw_j_reg;
    logic [12:0]    sw_acc_reg;
    logic [NDW-1:0] sw_nd_reg;
    logic [NDW-1:0] nd_total_reg;
    logic [NDW-1:0] cur_k_reg;
    logic [11:0]    sched_tau_reg;
    logic [11:0]    tau_reg;

    logic [CW-1:0] ptr_a_reg, ptr_b_reg, wr_k_reg, srch_base_reg;
    logic          pend_valid_reg;
    logic [11:0]   pend_f_reg;
    logic [31:0]   pend_v_reg;
    logic          srch_started_reg;
    logic [12:0]   last_target_reg, target_reg;
    logic [31:0]   vr_reg;
    logic [63:0]   prod_reg;
    logic [63:0]   psum_reg;
    logic [44:0]   past_reg, fut_reg;

    div_sel_t       div_sel_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic [63:0]    div_num_reg;
    logic [12:0]    div_rem_reg, div_den_reg;
    logic [47:0]    g2_reg;
    logic [31:0]    pm_reg, fm_reg;

    logic      m_valid_reg;
    smtc_out_t m_data_reg;

    function automatic logic [44:0] sat45(input logic [44:0] a, input logic [31:0] b);
        logic [45:0] s;
        s = {1'b0, a} + 46'(b);
        return s[45] ? '1 : s[44:0];
    endfunction

    // input value scaling
    logic [SHW-1:0] in_shift;
    logic [31:0]    in_value;
    assign in_shift = {s_data.event_value, FRAC_BITS'(0)};
    assign in_value = (64'(in_shift) > 64'hFFFF_FFFF) ? '1 : 32'(in_shift);

    logic [12:0] fc;
    assign fc = (frame_count_reg > FRAME_LIMIT) ? FRAME_LIMIT : frame_count_reg;

    // schedule walker
    logic [17:0] sw_step, sw_need;
    logic [6:0]  sw_per;
    logic        sw_done, sw_emit;
    logic [12:0] sw_tau;
    assign sw_step = 18'(1) << sw_lvl_reg;
    assign sw_need = 18'(sw_acc_reg) + (sw_step << 1);
    assign sw_per  = (sw_lvl_reg == 5'd0) ? {delays_reg, 1'b0} : {1'b0, delays_reg};
    assign sw_done = (sw_lvl_reg > {1'b0, max_level_reg}) || (sw_nd_reg == NDW'(MAX_DELAYS));
    assign sw_emit = !sw_done && (sw_j_reg < sw_per) && (sw_need <= 18'(fc));
    assign sw_tau  = sw_acc_reg + sw_step[12:0];

    // rebin datapath
    logic [11:0] reb_f;
    logic        reb_stop, reb_merge, reb_flush;
    logic [32:0] reb_sum;
    assign reb_f     = rd_frame_a_reg >> 1;
    assign reb_stop  = {1'b0, reb_f} >= bf_reg;
    assign reb_merge = pend_valid_reg && (reb_f == pend_f_reg);
    assign reb_flush = !reb_stop && !reb_merge && pend_valid_reg;
    assign reb_sum   = {1'b0, pend_v_reg} + {1'b0, rd_value_a_reg};

    // correlation datapath
    logic [12:0] cg_target;
    logic        cg_in, cg_fut;
    logic [64:0] mac_sum;
    assign cg_target = {1'b0, rd_frame_a_reg} + {1'b0, tau_reg};
    assign cg_in     = cg_target < bf_reg;
    assign cg_fut    = (rd_frame_a_reg >= tau_reg) && ({1'b0, rd_frame_a_reg} < bf_reg);
    assign mac_sum   = {1'b0, psum_reg} + {1'b0, prod_reg};

    // divider step
    logic [13:0] div_sh;
    logic        div_ge;
    logic [12:0] div_rem_new;
    logic [63:0] div_num_new, div_g2;
    logic [47:0] div_g2_sat;
    logic [31:0] div_q32_sat;
    assign div_sh      = {div_rem_reg, div_num_reg[63]};
    assign div_ge      = div_sh >= {1'b0, div_den_reg};
    assign div_rem_new = div_ge ? 13'(div_sh - {1'b0, div_den_reg}) : div_sh[12:0];
    assign div_num_new = {div_num_reg[62:0], div_ge};
    assign div_g2      = div_num_new >> FRAC_BITS;
    assign div_g2_sat  = (|div_g2[63:48]) ? '1 : div_g2[47:0];
    assign div_q32_sat = (|div_num_new[63:32]) ? '1 : div_num_new[31:0];

    // memory port control
    assign rd_addr_a = ptr_a_reg[AW-1:0];
    assign rd_addr_b = ptr_b_reg[AW-1:0];

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = event_total_reg[AW-1:0];
        mem_wframe = s_data.event_frame;
        mem_wvalue = in_value;
        if (state_reg == S_LOAD) begin
            mem_we = s_valid && (event_total_reg < CW'(MAX_EVENTS));
        end else if ((state_reg == S_REB_PROC && reb_flush) ||
                     (state_reg == S_REB_FLUSH && pend_valid_reg)) begin
            mem_we     = 1'b1;
            mem_waddr  = wr_k_reg[AW-1:0];
            mem_wframe = pend_f_reg;
            mem_wvalue = pend_v_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wframe;
            value_mem[mem_waddr] <= mem_wvalue;
        end
        rd_frame_a_reg <= frame_mem[rd_addr_a];
        rd_value_a_reg <= value_mem[rd_addr_a];
        rd_frame_b_reg <= frame_mem[rd_addr_b];
        rd_value_b_reg <= value_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_LOAD;
            frame_count_reg <= 13'd4096;
            delays_reg      <= 6'd4;
            max_level_reg   <= 4'd9;
            event_total_reg <= '0;
            pixel_reg       <= '0;
            bf_reg          <= '0;
            level_reg       <= '0;
            m_valid_reg     <= 1'b0;
            pend_valid_reg  <= 1'b0;
            srch_started_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_FRAME_COUNT: frame_count_reg <= cfg_data;
                    CFG_DELAYS:      delays_reg      <= cfg_data[5:0];
                    CFG_MAX_LEVEL:   max_level_reg   <= cfg_data[3:0];
                    default: ;
                endcase
            end
            // the emit state drives the output register itself
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD: begin
                    if (s_valid) begin
                        pixel_reg <= s_data.pixel_id;
                        if (event_total_reg < CW'(MAX_EVENTS)) begin
                            event_total_reg <= event_total_reg + 1'b1;
                        end
                        if (s_data.last_event) begin
                            sw_lvl_reg <= '0;
                            sw_j_reg   <= '0;
                            sw_acc_reg <= '0;
                            sw_nd_reg  <= '0;
                            bf_reg     <= fc;
                            level_reg  <= '0;
                            state_reg  <= S_COUNT;
                        end
                    end
                end
                S_COUNT: begin
                    if (sw_done) begin
                        nd_total_reg <= sw_nd_reg;
                        sw_lvl_reg   <= '0;
                        sw_j_reg     <= '0;
                        sw_acc_reg   <= '0;
                        sw_nd_reg    <= '0;
                        if (sw_nd_reg == '0) begin
                            event_total_reg <= '0;
                            level_reg       <= '0;
                            state_reg       <= S_LOAD;
                        end else begin
                            state_reg <= S_NEXT;
                        end
                    end else if (sw_emit) begin
                        sw_acc_reg <= sw_tau;
                        sw_j_reg   <= sw_j_reg + 1'b1;
                        sw_nd_reg  <= sw_nd_reg + 1'b1;
                    end else begin
                        sw_lvl_reg <= sw_lvl_reg + 1'b1;
                        sw_j_reg   <= '0;
                    end
                end
                S_NEXT: begin
                    if (sw_emit) begin
                        cur_k_reg     <= sw_nd_reg;
                        sched_tau_reg <= sw_tau[11:0];
                        tau_reg       <= 12'(sw_tau >> sw_lvl_reg);
                        sw_acc_reg    <= sw_tau;
                        sw_j_reg      <= sw_j_reg + 1'b1;
                        sw_nd_reg     <= sw_nd_reg + 1'b1;
                        if (sw_lvl_reg[3:0] != level_reg) begin
                            bf_reg         <= bf_reg >> 1;
                            level_reg      <= sw_lvl_reg[3:0];
                            ptr_a_reg      <= '0;
                            wr_k_reg       <= '0;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= S_REB_RD;
                        end else begin
                            state_reg <= S_CORR_INIT;
                        end
                    end else begin
                        sw_lvl_reg <= sw_lvl_reg + 1'b1;
                        sw_j_reg   <= '0;
                    end
                end
                S_REB_RD: begin
                    state_reg <= (ptr_a_reg < event_total_reg) ? S_REB_PROC : S_REB_FLUSH;
                end
                S_REB_PROC: begin
                    if (reb_stop) begin
                        state_reg <= S_REB_FLUSH;
                    end else begin
                        if (reb_merge) begin
                            pend_v_reg <= reb_sum[32] ? '1 : reb_sum[31:0];
                        end else begin
                            if (pend_valid_reg) begin
                                wr_k_reg <= wr_k_reg + 1'b1;
                            end
                            pend_f_reg     <= reb_f;
                            pend_v_reg     <= rd_value_a_reg;
                            pend_valid_reg <= 1'b1;
                        end
                        ptr_a_reg <= ptr_a_reg + 1'b1;
                        state_reg <= S_REB_RD;
                    end
                end
                S_REB_FLUSH: begin
                    event_total_reg <= pend_valid_reg ? wr_k_reg + 1'b1 : wr_k_reg;
                    pend_valid_reg  <= 1'b0;
                    state_reg       <= S_CORR_INIT;
                end
                S_CORR_INIT: begin
                    psum_reg         <= '0;
                    past_reg         <= '0;
                    fut_reg          <= '0;
                    ptr_a_reg        <= '0;
                    srch_started_reg <= 1'b0;
                    state_reg        <= S_CORR_RD;
                end
                S_CORR_RD: begin
                    if (ptr_a_reg < event_total_reg) begin
                        state_reg <= S_CORR_GET;
                    end else if (bf_reg > {1'b0, tau_reg}) begin
                        div_den_reg <= bf_reg - {1'b0, tau_reg};
                        div_sel_reg <= DS_PROD;
                        div_num_reg <= psum_reg;
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end else begin
                        g2_reg    <= '0;
                        pm_reg    <= '0;
                        fm_reg    <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_CORR_GET: begin
                    if (cg_fut) begin
                        fut_reg <= sat45(fut_reg, rd_value_a_reg);
                    end
                    if (cg_in) begin
                        past_reg   <= sat45(past_reg, rd_value_a_reg);
                        vr_reg     <= rd_value_a_reg;
                        target_reg <= cg_target;
                        // resume the probe where the last one stopped unless the target dropped
                        ptr_b_reg  <= (srch_started_reg && cg_target >= last_target_reg) ?
                                      srch_base_reg : '0;
                        last_target_reg  <= cg_target;
                        srch_started_reg <= 1'b1;
                        state_reg        <= S_SRCH_RD;
                    end else begin
                        ptr_a_reg <= ptr_a_reg + 1'b1;
                        state_reg <= S_CORR_RD;
                    end
                end
                S_SRCH_RD: begin
                    if (ptr_b_reg < event_total_reg) begin
                        state_reg <= S_SRCH_CHK;
                    end else begin
                        srch_base_reg <= ptr_b_reg;
                        ptr_a_reg     <= ptr_a_reg + 1'b1;
                        state_reg     <= S_CORR_RD;
                    end
                end
                S_SRCH_CHK: begin
                    if ({1'b0, rd_frame_b_reg} >= target_reg) begin
                        srch_base_reg <= ptr_b_reg;
                        if ({1'b0, rd_frame_b_reg} == target_reg) begin
                            prod_reg  <= 64'(vr_reg) * 64'(rd_value_b_reg);
                            state_reg <= S_MAC;
                        end else begin
                            ptr_a_reg <= ptr_a_reg + 1'b1;
                            state_reg <= S_CORR_RD;
                        end
                    end else begin
                        ptr_b_reg <= ptr_b_reg + 1'b1;
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_MAC: begin
                    psum_reg  <= mac_sum[64] ? '1 : mac_sum[63:0];
                    ptr_a_reg <= ptr_a_reg + 1'b1;
                    state_reg <= S_CORR_RD;
                end
                S_DIV: begin
                    if (div_cnt_reg == DCW'(DIV_STEPS - 1)) begin
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        case (div_sel_reg)
                            DS_PROD: begin
                                g2_reg      <= div_g2_sat;
                                div_num_reg <= 64'(past_reg);
                                div_sel_reg <= DS_PAST;
                            end
                            DS_PAST: begin
                                pm_reg      <= div_q32_sat;
                                div_num_reg <= 64'(fut_reg);
                                div_sel_reg <= DS_FUT;
                            end
                            default: begin
                                fm_reg    <= div_q32_sat;
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end else begin
                        div_rem_reg <= div_rem_new;
                        div_num_reg <= div_num_new;
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg              <= 1'b1;
                        m_data_reg.out_pixel     <= pixel_reg;
                        m_data_reg.delay_index   <= 6'(cur_k_reg);
                        m_data_reg.delay_frames  <= sched_tau_reg;
                        m_data_reg.g2_mean       <= g2_reg;
                        m_data_reg.past_mean     <= pm_reg;
                        m_data_reg.future_mean   <= fm_reg;
                        m_data_reg.last_result   <= (cur_k_reg + 1'b1 == nd_total_reg);
                        if (cur_k_reg + 1'b1 == nd_total_reg) begin
                            event_total_reg <= '0;
                            level_reg       <= '0;
                            state_reg       <= S_LOAD;
                        end else begin
                            state_reg <= S_NEXT;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign s_ready   = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

### rtl/core/smtc_checker.sv
`include "sparse_multitau_correlator_defines.svh"

module smtc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input smtc_pkg::smtc_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input smtc_pkg::smtc_out_t m_data
);
    import smtc_pkg::*;

    `SMTC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `SMTC_ASSERT_NEXT(a_busy_after_last, s_valid && s_ready && s_data.last_event, !s_ready, "input still open after final event")
    `SMTC_ASSERT_NEXT(a_load_continues, s_valid && s_ready && !s_data.last_event, s_ready, "input closed before final event")
    `SMTC_ASSERT_NOW(a_mid_pixel_busy, m_valid && !m_data.last_result, !s_ready, "input open while pixel results pending")

endmodule

bind sparse_multitau_correlator smtc_checker u_smtc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### verif/smtc_result_checker.sv
`timescale 1ns / 100ps

module smtc_result_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  smtc_pkg::smtc_in_t                    s_data,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  smtc_pkg::smtc_out_t                   m_data,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [smtc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [smtc_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                    mismatches,
    output int                                    outstanding
);
    import smtc_pkg::*;

    localparam int EVENT_DEPTH = 4096;
    localparam int DELAY_CAP   = 64;
    localparam longint unsigned SUM45_MAX = (64'd1 << 45) - 1;
    localparam longint unsigned MASK48    = (64'd1 << 48) - 1;
    localparam longint unsigned MASK32    = 64'hFFFF_FFFF;

    // shadow of the block's registers and event memory
    logic [12:0]     frames_cfg;
    logic [5:0]      delays_cfg;
    logic [3:0]      level_cfg;
    int unsigned     ev_frame [EVENT_DEPTH];
    int unsigned     ev_value [EVENT_DEPTH];
    int unsigned     ev_count;
    int unsigned     pixel_now;
    int unsigned     bins_now;
    longint unsigned prod_acc;
    longint unsigned past_acc;
    longint unsigned future_acc;

    smtc_out_t g2_expected [$];

    assign outstanding = g2_expected.size();

    function automatic longint unsigned add_sat64(longint unsigned a, longint unsigned b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic longint unsigned add_sat45(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > SUM45_MAX) ? SUM45_MAX : s;
    endfunction

    task automatic halve_bins();
        int unsigned k, cnt, prev, f, i;
        logic [32:0] s;
        k = 0;
        cnt = 0;
        prev = 0;
        bins_now = bins_now >> 1;
        if (ev_count > 0) begin
            f = ev_frame[0] >> 1;
            if (f < bins_now) begin
                ev_frame[0] = f;
                prev = f;
                k = 1;
                cnt = 1;
            end else begin
                // first event falls out: drop the whole list
                cnt = ev_count;
            end
        end
        while (cnt < ev_count) begin
            f = ev_frame[cnt] >> 1;
            if (f >= bins_now) break;
            if (f == prev) begin
                s = {1'b0, ev_value[k-1]} + {1'b0, ev_value[cnt]};
                ev_value[k-1] = s[32] ? 32'hFFFF_FFFF : s[31:0];
            end else begin
                ev_frame[k] = f;
                ev_value[k] = ev_value[cnt];
                k++;
            end
            prev = f;
            cnt++;
        end
        ev_count = k;
        for (i = 0; i < k; i++) ev_value[i] = ev_value[i] >> 1;
    endtask

    task automatic sum_lag(int unsigned tau);
        int unsigned r, j, src, tgt;
        prod_acc = 0;
        past_acc = 0;
        future_acc = 0;
        for (r = 0; r < ev_count; r++) begin
            src = ev_frame[r];
            tgt = src + tau;
            if (tgt < bins_now) begin
                past_acc = add_sat45(past_acc, ev_value[r]);
                for (j = 0; j < ev_count; j++)
                    if (ev_frame[j] >= tgt) break;
                if (j < ev_count && ev_frame[j] == tgt)
                    prod_acc = add_sat64(prod_acc,
                        longint'(ev_value[r]) * longint'(ev_value[j]));
            end
            if (src >= tau && src < bins_now)
                future_acc = add_sat45(future_acc, ev_value[r]);
        end
    endtask

    task automatic predict_pixel_event(smtc_in_t it);
        int unsigned lvl_of [DELAY_CAP];
        int unsigned lag_of [DELAY_CAP];
        int unsigned nd, acc, fc, lvl, step, per, j, k, tau, d, level_now;
        longint unsigned g2, pm, fm;
        smtc_out_t res;
        nd = 0;
        acc = 0;
        pixel_now = it.pixel_id;
        if (ev_count < EVENT_DEPTH) begin
            ev_frame[ev_count] = it.event_frame;
            ev_value[ev_count] = {it.event_value, 16'h0};
            ev_count++;
        end
        if (!it.last_event) return;

        fc = (frames_cfg > FRAME_LIMIT) ? FRAME_LIMIT : frames_cfg;
        for (lvl = 0; lvl <= level_cfg && nd < DELAY_CAP; lvl++) begin
            step = 1 << lvl;
            per = (lvl == 0) ? 2 * delays_cfg : delays_cfg;
            for (j = 0; j < per && nd < DELAY_CAP; j++) begin
                if (acc + 2 * step > fc) break;
                lvl_of[nd] = lvl;
                lag_of[nd] = acc + step;
                acc += step;
                nd++;
            end
        end

        bins_now = fc;
        level_now = 0;
        for (k = 0; k < nd; k++) begin
            if (lvl_of[k] != level_now) begin
                halve_bins();
                level_now = lvl_of[k];
            end
            tau = lag_of[k] >> lvl_of[k];
            sum_lag(tau);
            d = (bins_now > tau) ? bins_now - tau : 0;
            if (d > 0) begin
                g2 = (prod_acc / d) >> 16;
                pm = past_acc / d;
                fm = future_acc / d;
            end else begin
                g2 = 0;
                pm = 0;
                fm = 0;
            end
            res.out_pixel    = pixel_now[19:0];
            res.delay_index  = k[5:0];
            res.delay_frames = lag_of[k][11:0];
            res.g2_mean      = (g2 > MASK48) ? MASK48[47:0] : g2[47:0];
            res.past_mean    = (pm > MASK32) ? MASK32[31:0] : pm[31:0];
            res.future_mean  = (fm > MASK32) ? MASK32[31:0] : fm[31:0];
            res.last_result  = (k + 1 == nd);
            g2_expected = {g2_expected, res};
        end
        ev_count = 0;
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic compare_result(smtc_out_t got);
        smtc_out_t want;
        if (g2_expected.size() == 0) begin
            report_mismatch("unexpected result, pixel", got.out_pixel, 0);
            return;
        end
        want = g2_expected.pop_front();
        if (got.out_pixel != want.out_pixel)
            report_mismatch("out_pixel", got.out_pixel, want.out_pixel);
        if (got.delay_index != want.delay_index)
            report_mismatch("delay_index", got.delay_index, want.delay_index);
        if (got.delay_frames != want.delay_frames)
            report_mismatch("delay_frames", got.delay_frames, want.delay_frames);
        if (got.g2_mean != want.g2_mean)
            report_mismatch("g2_mean", got.g2_mean, want.g2_mean);
        if (got.past_mean != want.past_mean)
            report_mismatch("past_mean", got.past_mean, want.past_mean);
        if (got.future_mean != want.future_mean)
            report_mismatch("future_mean", got.future_mean, want.future_mean);
        if (got.last_result != want.last_result)
            report_mismatch("last_result", got.last_result, want.last_result);
    endtask

    initial mismatches = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            frames_cfg = 13'd4096;
            delays_cfg = 6'd4;
            level_cfg  = 4'd9;
            ev_count   = 0;
            pixel_now  = 0;
            bins_now   = 0;
            g2_expected.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_COUNT: frames_cfg = cfg_data;
                    CFG_DELAYS:      delays_cfg = cfg_data[5:0];
                    CFG_MAX_LEVEL:   level_cfg  = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) compare_result(m_data);
            if (s_valid && s_ready) predict_pixel_event(s_data);
        end
    end

endmodule

### verif/sparse_multitau_correlator_tb.sv
`timescale 1ns / 100ps

module sparse_multitau_correlator_tb;
    import smtc_pkg::*;

    localparam int SETTLE_CYCLES = 4000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    smtc_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    smtc_out_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;

    bit          calm;
    int          events_sent;
    int unsigned span_now;

    sparse_multitau_correlator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    smtc_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #400_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver stalls at random except during calm stretches
    always @(negedge aclk) m_ready <= calm || ($urandom_range(99) >= 38);

    task automatic send_event(smtc_in_t it);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        events_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // hold until every result is out and the block has had time to go idle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(int unsigned fc, int unsigned dpl, int unsigned lvl);
        drain();
        write_reg(CFG_FRAME_COUNT, fc[12:0]);
        write_reg(CFG_DELAYS, dpl[12:0]);
        write_reg(CFG_MAX_LEVEL, lvl[12:0]);
        span_now = (fc == 0) ? 1 : ((fc > 4096) ? 4096 : fc);
    endtask

    function automatic logic [15:0] pick_count();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // one pixel: mostly rising frames inside the series, some noise
    task automatic send_pixel(int nev, bit tidy);
        smtc_in_t it;
        int unsigned f, gap;
        int i;
        it.pixel_id = 20'($urandom_range(20'hFFFFF));
        gap = span_now / nev + 1;
        f = $urandom_range(gap - 1);
        for (i = 0; i < nev; i++) begin
            if (!tidy || $urandom_range(7) == 0) it.event_frame = 12'($urandom_range(4095));
            else it.event_frame = 12'((f > 4095) ? 4095 : f);
            f += $urandom_range(gap);
            if ($urandom_range(19) == 0) it.pixel_id = 20'($urandom_range(20'hFFFFF));
            it.event_value = pick_count();
            it.last_event = (i == nev - 1);
            send_event(it);
        end
    endtask

    initial begin
        smtc_in_t it;
        int pixels;
        int unsigned fc;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_COUNT;
        cfg_data = '0;
        m_ready = 1'b0;
        calm = 1'b0;
        events_sent = 0;
        span_now = 4096;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: field extremes, duplicate and unordered frames
        it = '{pixel_id: 20'hFFFFF, event_frame: 12'd0, event_value: 16'hFFFF, last_event: 1'b0};
        send_event(it);
        it = '{pixel_id: 20'hFFFFF, event_frame: 12'd1, event_value: 16'hFFFF, last_event: 1'b0};
        send_event(it);
        it.event_frame = 12'd1;
        send_event(it);
        it.event_frame = 12'd3;
        it.event_value = 16'h0;
        send_event(it);
        it.event_frame = 12'd2;
        it.event_value = 16'h8001;
        send_event(it);
        it = '{pixel_id: 20'h0, event_frame: 12'hFFF, event_value: 16'h0, last_event: 1'b1};
        send_event(it);

        // smallest nonzero settings: empty schedule
        configure(1, 1, 0);
        it = '{pixel_id: 20'h5A5A5, event_frame: 12'd0, event_value: 16'h1234, last_event: 1'b1};
        send_event(it);

        // zero everywhere, then out-of-range register values
        configure(0, 0, 0);
        send_pixel(2, 1);
        configure(8191, 63, 15);
        send_pixel(4, 1);

        // widest in-range settings hit the delay cap
        configure(4096, 32, 12);
        send_pixel(6, 1);

        // first event lands past the halved frame count
        configure(7, 1, 2);
        it = '{pixel_id: 20'h00001, event_frame: 12'd6, event_value: 16'h00FF, last_event: 1'b0};
        send_event(it);
        it.event_frame = 12'd2;
        it.last_event = 1'b1;
        send_event(it);

        pixels = 0;
        while (events_sent < 410) begin
            if (pixels % 8 == 0) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: fc = $urandom_range(1, 64);
                    6, 7:             fc = $urandom_range(65, 4096);
                    8:                fc = 4096;
                    default:          fc = $urandom_range(8191);
                endcase
                configure(fc,
                          ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(1, 6),
                          ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(12));
            end
            // one long stretch with no random stalls on either side
            calm = (pixels >= 24 && pixels < 36);
            if (pixels == 20) drain();
            send_pixel(($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8),
                       $urandom_range(4) != 0);
            pixels++;
        end
        calm = 1'b0;

        drain();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
